// ===== rtl/drid_pkg.sv =====
`timescale 1ns / 1ps

package drid_pkg;

   // request action codes
   localparam logic [2:0] ACT_WRITE   = 3'd0;
   localparam logic [2:0] ACT_READ    = 3'd1;
   localparam logic [2:0] ACT_CLEAR   = 3'd2;
   localparam logic [2:0] ACT_SET_ALL = 3'd3;
   localparam logic [2:0] ACT_REFRESH = 3'd4;
   localparam logic [2:0] ACT_DIM     = 3'd5;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_LEFT_ALIGNED   = 2'd0;
   localparam logic [1:0] REG_DIGIT_COUNT    = 2'd1;
   localparam logic [1:0] REG_REGISTER_COUNT = 2'd2;
   localparam logic [1:0] REG_DUTY           = 2'd3;

   localparam int UPC_W = 4;

   // microprogram addresses
   localparam logic [UPC_W-1:0] UPC_FETCH        = 4'd0;
   localparam logic [UPC_W-1:0] UPC_WRITE        = 4'd1;
   localparam logic [UPC_W-1:0] UPC_READ         = 4'd2;
   localparam logic [UPC_W-1:0] UPC_CLEAR_FILL   = 4'd3;
   localparam logic [UPC_W-1:0] UPC_BLANK_FRAME  = 4'd4;
   localparam logic [UPC_W-1:0] UPC_SET_FILL     = 4'd5;
   localparam logic [UPC_W-1:0] UPC_DATA_FRAME   = 4'd6;
   localparam logic [UPC_W-1:0] UPC_DIM_BRANCH   = 4'd7;
   localparam logic [UPC_W-1:0] UPC_DIM_BLANK    = 4'd8;
   localparam logic [UPC_W-1:0] UPC_DIM_DATA_OPT = 4'd9;
   localparam logic [UPC_W-1:0] UPC_BRT_DATA     = 4'd10;
   localparam logic [UPC_W-1:0] UPC_BRT_BLANK_OPT = 4'd11;
   localparam logic [UPC_W-1:0] UPC_ADVANCE      = 4'd12;

   typedef enum logic [2:0] {
      OP_FETCH,
      OP_WRITE,
      OP_READ,
      OP_FILL,
      OP_BRANCH,
      OP_FRAME,
      OP_ADVANCE
   } op_type;

   typedef struct packed {
      op_type           op;
      logic             blank;      // frame of zeros
      logic             fill_ones;  // fill with 255, else zero
      logic             cond;       // frame only if the second-frame test passes
      logic [UPC_W-1:0] next;
      logic [UPC_W-1:0] alt;        // branch target when on time exceeds off time
   } cw_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic cw_type microcode(input logic [UPC_W-1:0] upc);
      cw_type cw;
      cw = '{op: OP_FETCH, blank: 1'b0, fill_ones: 1'b0, cond: 1'b0,
             next: UPC_FETCH, alt: UPC_FETCH};
      unique case (upc)
         UPC_FETCH:        cw.op = OP_FETCH;
         UPC_WRITE:        cw.op = OP_WRITE;
         UPC_READ:         cw.op = OP_READ;
         UPC_CLEAR_FILL: begin
            cw.op   = OP_FILL;
            cw.next = UPC_BLANK_FRAME;
         end
         UPC_BLANK_FRAME: begin
            cw.op    = OP_FRAME;
            cw.blank = 1'b1;
         end
         UPC_SET_FILL: begin
            cw.op        = OP_FILL;
            cw.fill_ones = 1'b1;
            cw.next      = UPC_DATA_FRAME;
         end
         UPC_DATA_FRAME:   cw.op = OP_FRAME;
         UPC_DIM_BRANCH: begin
            cw.op   = OP_BRANCH;
            cw.next = UPC_DIM_BLANK;
            cw.alt  = UPC_BRT_DATA;
         end
         UPC_DIM_BLANK: begin
            cw.op    = OP_FRAME;
            cw.blank = 1'b1;
            cw.next  = UPC_DIM_DATA_OPT;
         end
         UPC_DIM_DATA_OPT: begin
            cw.op   = OP_FRAME;
            cw.cond = 1'b1;
            cw.next = UPC_ADVANCE;
         end
         UPC_BRT_DATA: begin
            cw.op   = OP_FRAME;
            cw.next = UPC_BRT_BLANK_OPT;
         end
         UPC_BRT_BLANK_OPT: begin
            cw.op    = OP_FRAME;
            cw.blank = 1'b1;
            cw.cond  = 1'b1;
            cw.next  = UPC_ADVANCE;
         end
         UPC_ADVANCE:      cw.op = OP_ADVANCE;
         default:          cw.op = OP_FETCH;
      endcase
      return cw;
   endfunction

   function automatic logic [UPC_W-1:0] dispatch(input logic [2:0] action);
      logic [UPC_W-1:0] target;
      unique case (action)
         ACT_WRITE:   target = UPC_WRITE;
         ACT_READ:    target = UPC_READ;
         ACT_CLEAR:   target = UPC_CLEAR_FILL;
         ACT_SET_ALL: target = UPC_SET_FILL;
         ACT_REFRESH: target = UPC_DATA_FRAME;
         ACT_DIM:     target = UPC_DIM_BRANCH;
         default:     target = UPC_FETCH;
      endcase
      return target;
   endfunction

endpackage

// ===== rtl/drid_divider.sv =====
`timescale 1ns / 1ps

// Restoring 8-bit divider, one quotient bit per cycle.
module drid_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [7:0]              dividend,
   input  logic [7:0]              divisor,
   output drid_pkg::div_status_type status,
   output logic [7:0]              quotient
);

   logic       busy_ff;
   logic       done_ff;
   logic [2:0] count_ff;
   logic [7:0] rem_ff;
   logic [7:0] rem_in;
   logic [7:0] quo_ff;
   logic [7:0] quo_in;
   logic [7:0] den_ff;
   logic [8:0] trial;

   always_comb begin
      trial = {rem_ff, quo_ff[7]} - {1'b0, den_ff};
      if (!trial[8]) begin
         rem_in = trial[7:0];
         quo_in = {quo_ff[6:0], 1'b1};
      end else begin
         rem_in = {rem_ff[6:0], quo_ff[7]};
         quo_in = {quo_ff[6:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 3'd0;
      end else begin
         done_ff <= busy_ff && !start && (count_ff == 3'd7);
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= 3'd0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 3'd1;
            if (count_ff == 3'd7) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 8'd0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== rtl/display_refresh_interlace_dimmer.sv =====
`timescale 1ns / 1ps

// Display memory and frame shifter for a high-voltage shift-register display
// driver, with interlaced on/off dimming. Requests are run by a small
// microprogram; one request is handled at a time. A request is taken in the
// idle cycle of the microprogram; it then does a write or a read, sends a frame
// of N bytes for refresh, or fills the memory and sends a frame for clear and
// set all, where N is the frame length. A dimming tick branches, sends its
// first frame, then a second frame or skips it, and updates the phase; at zero
// duty it branches and sends one blank frame. Frame bytes leave one per cycle
// while the response side keeps ready high; a stalled response holds the
// sequencer. Writing a duty with nonzero on and off times starts a bit-serial
// divide that derives the on/off ratio; requests are held off until it finishes.
module display_refresh_interlace_dimmer #(
   parameter int MAX_REGISTERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [2:0]  req_position,
   input  logic [7:0]  req_write_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_read_reply,
   output logic        rsp_frame_blank,
   output logic        rsp_frame_last,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
   localparam logic [5:0] MAX_LEN = 6'(MAX_REGISTERS);

   // configuration
   logic       left_aligned_ff;
   logic [3:0] digit_count_ff;
   logic [3:0] register_count_ff;
   logic [7:0] duty_ff;
   logic [7:0] ratio_ff;

   // dimming state
   logic [7:0] loop_ff;
   logic [7:0] loop_in;
   logic [7:0] phase_ff;
   logic [7:0] phase_in;
   logic       advance;

   // sequencer
   logic [drid_pkg::UPC_W-1:0] upc_ff;
   logic [drid_pkg::UPC_W-1:0] upc_in;
   logic [IW-1:0]              cnt_ff;
   logic [IW-1:0]              cnt_in;
   drid_pkg::cw_type           cw;

   logic [2:0] pos_ff;
   logic [7:0] wbyte_ff;

   logic [7:0] mem_ff [MAX_REGISTERS];
   logic       mem_we;
   logic       fill_en;
   logic [IW-1:0] rd_addr;
   logic [7:0]    rd_data;

   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   logic       is_read_ff;
   logic       blank_ff;
   logic       last_ff;
   logic       load;
   logic [7:0] load_byte;
   logic       load_read;
   logic       load_last;
   logic       slot_free;

   logic       req_fire;
   logic       cfg_we;
   logic       duty_we;
   logic [7:0] new_on;
   logic [7:0] new_off;
   logic [7:0] div_num;
   logic [7:0] div_den;
   drid_pkg::div_status_type div_status;
   logic [7:0] div_quo;

   logic [7:0] on_t;
   logic [7:0] off_t;
   logic       off_gt_on;
   logic       extra_ok;
   logic [7:0] limit;
   logic [7:0] phase_p1;
   logic [7:0] loop_p1;

   logic [5:0] frame_len;
   logic [4:0] idx;
   logic       idx_ok;
   logic       last_byte;

   function automatic logic [15:0] on_off(input logic [7:0] d);
      logic [7:0] on;
      logic [7:0] off;
      if (d == 8'd0) begin
         on  = 8'd0;
         off = 8'd0;
      end else if (d == 8'hFF) begin
         on  = 8'd1;
         off = 8'd0;
      end else begin
         on  = d;
         off = 8'hFF - d;
      end
      return {on, off};
   endfunction

   // ---------------- configuration ----------------
   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite;
   assign duty_we = cfg_we && (paddr[3:2] == drid_pkg::REG_DUTY);

   assign {new_on, new_off} = on_off(pwdata[7:0]);
   // one of on/off is always the smaller, so a single quotient serves both ratios
   assign div_num = (new_on > new_off) ? new_on : new_off;
   assign div_den = (new_on > new_off) ? new_off : new_on;

   drid_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (duty_we && (div_den != 8'd0)),
      .dividend (div_num),
      .divisor  (div_den),
      .status   (div_status),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         left_aligned_ff   <= 1'b1;
         digit_count_ff    <= 4'd8;
         register_count_ff <= 4'd4;
         duty_ff           <= 8'hFF;
         ratio_ff          <= 8'd0;
      end else begin
         if (cfg_we) begin
            unique case (paddr[3:2])
               drid_pkg::REG_LEFT_ALIGNED:   left_aligned_ff   <= pwdata[0];
               drid_pkg::REG_DIGIT_COUNT:    digit_count_ff    <= pwdata[3:0];
               drid_pkg::REG_REGISTER_COUNT: register_count_ff <= pwdata[3:0];
               drid_pkg::REG_DUTY: begin
                  duty_ff  <= pwdata[7:0];
                  ratio_ff <= 8'd0;
               end
               default: ;
            endcase
         end else if (div_status.done) begin
            ratio_ff <= div_quo;
         end
      end
   end

   always_comb begin
      prdata = 32'd0;
      unique case (paddr[3:2])
         drid_pkg::REG_LEFT_ALIGNED:   prdata = {31'd0, left_aligned_ff};
         drid_pkg::REG_DIGIT_COUNT:    prdata = {28'd0, digit_count_ff};
         drid_pkg::REG_REGISTER_COUNT: prdata = {28'd0, register_count_ff};
         drid_pkg::REG_DUTY:           prdata = {24'd0, duty_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      if (register_count_ff == 4'd0)
         frame_len = 6'd1;
      else if ({2'b00, register_count_ff} > MAX_LEN)
         frame_len = MAX_LEN;
      else
         frame_len = {2'b00, register_count_ff};
   end

   // mirrored position for left-aligned digits
   always_comb begin
      if (left_aligned_ff && ({1'b0, pos_ff} < digit_count_ff))
         idx = {1'b0, digit_count_ff - {1'b0, pos_ff} - 4'd1};
      else
         idx = {2'b00, pos_ff};
   end
   assign idx_ok = {1'b0, idx} < MAX_LEN;

   assign {on_t, off_t} = on_off(duty_ff);
   assign off_gt_on = off_t > on_t;
   assign extra_ok  = (ratio_ff != 8'd0) && (phase_ff == 8'd0) &&
                      (off_gt_on ? (on_t != 8'd0) : (off_t != 8'd0));
   assign limit     = off_gt_on ? off_t : on_t;

   assign cw        = drid_pkg::microcode(upc_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (cw.op == drid_pkg::OP_FETCH) && !div_status.busy;
   assign req_fire  = req_valid && req_ready;

   assign rd_addr   = (cw.op == drid_pkg::OP_READ) ? IW'(idx) : cnt_ff;
   assign rd_data   = mem_ff[rd_addr];
   assign last_byte = ({{(6-IW){1'b0}}, cnt_ff} + 6'd1) == frame_len;

   always_comb begin
      phase_p1 = phase_ff + 8'd1;
      loop_p1  = loop_ff + 8'd1;
      phase_in = phase_ff;
      loop_in  = loop_p1;
      if (ratio_ff != 8'd0)
         phase_in = (phase_p1 >= ratio_ff) ? 8'd0 : phase_p1;
      if (loop_p1 >= limit) begin
         loop_in  = 8'd0;
         phase_in = 8'd0;
      end
   end

   // sequencer step
   always_comb begin
      upc_in    = upc_ff;
      cnt_in    = cnt_ff;
      mem_we    = 1'b0;
      fill_en   = 1'b0;
      advance   = 1'b0;
      load      = 1'b0;
      load_byte = rd_data;
      load_read = 1'b0;
      load_last = 1'b0;
      unique case (cw.op)
         drid_pkg::OP_FETCH: begin
            if (req_fire) upc_in = drid_pkg::dispatch(req_action);
         end
         drid_pkg::OP_WRITE: begin
            mem_we = ({3'b000, pos_ff} < frame_len) && idx_ok;
            upc_in = cw.next;
         end
         drid_pkg::OP_READ: begin
            if (slot_free) begin
               load      = 1'b1;
               load_read = 1'b1;
               load_byte = idx_ok ? rd_data : 8'd0;
               upc_in    = cw.next;
            end
         end
         drid_pkg::OP_FILL: begin
            fill_en = 1'b1;
            upc_in  = cw.next;
         end
         drid_pkg::OP_BRANCH: begin
            if (off_gt_on)
               upc_in = cw.next;
            else if (on_t == 8'd0)
               upc_in = drid_pkg::UPC_BLANK_FRAME;
            else
               upc_in = cw.alt;
         end
         drid_pkg::OP_FRAME: begin
            if (cw.cond && !extra_ok) begin
               upc_in = cw.next;
            end else if (slot_free) begin
               load      = 1'b1;
               load_byte = cw.blank ? 8'd0 : rd_data;
               load_last = last_byte;
               if (last_byte) begin
                  cnt_in = '0;
                  upc_in = cw.next;
               end else begin
                  cnt_in = cnt_ff + IW'(1);
               end
            end
         end
         drid_pkg::OP_ADVANCE: begin
            advance = 1'b1;
            upc_in  = cw.next;
         end
         default: upc_in = drid_pkg::UPC_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff   <= drid_pkg::UPC_FETCH;
         cnt_ff   <= '0;
         loop_ff  <= 8'd0;
         phase_ff <= 8'd0;
      end else begin
         upc_ff <= upc_in;
         cnt_ff <= cnt_in;
         if (duty_we) begin
            loop_ff  <= 8'd0;
            phase_ff <= 8'd0;
         end else if (advance) begin
            loop_ff  <= loop_in;
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pos_ff   <= req_position;
         wbyte_ff <= req_write_byte;
      end
   end

   // display memory
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_REGISTERS; i++) mem_ff[i] <= 8'd0;
      end else if (fill_en) begin
         for (int i = 0; i < MAX_REGISTERS; i++) begin
            if (6'(i) < frame_len) mem_ff[i] <= cw.fill_ones ? 8'hFF : 8'd0;
         end
      end else if (mem_we) begin
         mem_ff[IW'(idx)] <= wbyte_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= load_byte;
         is_read_ff  <= load_read;
         blank_ff    <= cw.blank && !load_read;
         last_ff     <= load_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_is_read_reply = is_read_ff;
   assign rsp_frame_blank   = blank_ff;
   assign rsp_frame_last    = last_ff;

endmodule
